/* rtl/core/cobs_frame_encoder_defines.svh */
// Assertion macros shared by the COBS frame encoder RTL
`ifndef COBS_FRAME_ENCODER_DEFINES_SVH
`define COBS_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CFE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cobs_frame_encoder: assertion failed");

// Next-cycle implication, disabled while in reset
`define CFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cobs_frame_encoder: assertion failed");

`endif

/* rtl/core/cfe_pkg.sv */
// Types and constants of the COBS frame encoder
package cfe_pkg;

   localparam int BLOCK_MAX = 254;
   localparam int FILL_W    = 8;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   localparam logic [7:0] DELIMITER = 8'h00;

   typedef struct packed {
      logic       operation;
      logic [7:0] raw_byte;
      logic       raw_last;
   } cfe_item_type;

   typedef struct packed {
      logic       push_taken;
      logic       byte_valid;
      logic [7:0] coded_byte;
      logic       frame_done;
      logic       drain_busy;
   } cfe_result_type;

endpackage

/* rtl/core/cobs_frame_encoder.sv */
// Top level of the COBS frame encoder: stream ports, register and result stage
//
// COBS frame encoder. Each req item either pushes one raw frame byte (tuser 0)
// or pulls one encoded byte (tuser 1); every item yields exactly one rsp item.
// Up to 254 nonzero bytes are held in an on-chip block store; a zero byte, a
// full run or the frame's last byte closes the block, after which pulls return
// the code byte, the data bytes, an extra 0x01 code where the frame ended on a
// zero or a full run, and the optional 0x00 delimiter. Pushes during a drain
// come back with push_taken low. One item is accepted per clock unless rsp is
// stalled: the store is prefetched ahead of each pull, and the registered rsp
// stage accepts a new item in the same cycle its held result is taken.
// The delimiter enable is sampled when a frame's last byte is pushed.
`include "cobs_frame_encoder_defines.svh"
module cobs_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] raw_byte
   input  logic [0:0]  req_tuser,   // [0] operation
   input  logic        req_tlast,   // raw_last
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] push_taken, [1] byte_valid,
                                    // [9:2] coded_byte, [10] drain_busy
   output logic        rsp_tlast,   // frame_done
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // append_delimiter
);
   import cfe_pkg::*;

   logic           step;
   cfe_item_type   item;
   cfe_result_type result;
   cfe_result_type rsp_res_ff;
   logic           rsp_valid_ff;
   logic           append_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign item.operation = req_tuser[0];
   assign item.raw_byte  = req_tdata;
   assign item.raw_last  = req_tlast;

   cfe_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .item             (item),
      .append_delimiter (append_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         append_ff    <= 1'b1;
      end else begin
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            append_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_res_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_res_ff.drain_busy, rsp_res_ff.coded_byte,
                        rsp_res_ff.byte_valid, rsp_res_ff.push_taken};
   assign rsp_tlast  = rsp_res_ff.frame_done;

   `CFE_ASSERT_IMPL(a_done_needs_byte, clock, reset, rsp_valid_ff && rsp_res_ff.frame_done, rsp_res_ff.byte_valid)
   `CFE_ASSERT_IMPL(a_done_ends_drain, clock, reset, rsp_valid_ff && rsp_res_ff.frame_done, !rsp_res_ff.drain_busy)
   `CFE_ASSERT_IMPL(a_push_or_pull, clock, reset, rsp_valid_ff, !(rsp_res_ff.push_taken && rsp_res_ff.byte_valid))
   `CFE_ASSERT_NEXT(a_item_gives_result, clock, reset, step, rsp_valid_ff)

endmodule

/* rtl/core/cfe_ram.sv */
// Generic single-write, single-read RAM with registered read data
module cfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 254,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cfe_core.sv */
// COBS block buffer, drain sequencing and per-item result logic
module cfe_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  cfe_pkg::cfe_item_type   item,
   input  logic                    append_delimiter,
   output cfe_pkg::cfe_result_type result
);
   import cfe_pkg::*;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] pos_ff, pos_in;
   logic              draining_ff, draining_in;
   logic              tail_ff, tail_in;
   logic              delim_ff, delim_in;
   logic              closing_ff, closing_in;

   logic              wr_en;
   logic [FILL_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic [FILL_W-1:0] fill_inc;
   logic              is_zero;

   always_comb begin
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      draining_in = draining_ff;
      tail_in     = tail_ff;
      delim_in    = delim_ff;
      closing_in  = closing_ff;
      result      = '0;
      wr_en       = 1'b0;
      fill_inc    = fill_ff + FILL_W'(1);
      is_zero     = (item.raw_byte == DELIMITER);

      if (step) begin
         if (item.operation == OP_PUSH) begin
            if (!draining_ff) begin
               result.push_taken = 1'b1;
               if (!is_zero) begin
                  wr_en   = 1'b1;
                  fill_in = fill_inc;
               end
               // zero byte, full run or end of frame closes the block
               if (is_zero || fill_in == FILL_W'(BLOCK_MAX) || item.raw_last) begin
                  draining_in = 1'b1;
                  pos_in      = '0;
                  tail_in     = item.raw_last &&
                                (is_zero || fill_in == FILL_W'(BLOCK_MAX));
                  closing_in  = item.raw_last;
                  delim_in    = item.raw_last && append_delimiter;
               end
            end
         end else if (draining_ff) begin
            result.byte_valid = 1'b1;
            if (pos_ff <= fill_ff) begin
               result.coded_byte = (pos_ff == '0) ? fill_inc : rd_data;
               pos_in = pos_ff + FILL_W'(1);
               if (pos_ff == fill_ff) begin
                  if (tail_ff) begin
                     // follow with an empty block: code byte only
                     fill_in = '0;
                     pos_in  = '0;
                     tail_in = 1'b0;
                  end else if (!delim_ff) begin
                     result.frame_done = closing_ff;
                     draining_in = 1'b0;
                     fill_in     = '0;
                     pos_in      = '0;
                     closing_in  = 1'b0;
                  end
               end
            end else begin
               result.coded_byte = DELIMITER;
               result.frame_done = 1'b1;
               draining_in = 1'b0;
               fill_in     = '0;
               pos_in      = '0;
               tail_in     = 1'b0;
               delim_in    = 1'b0;
               closing_in  = 1'b0;
            end
         end
      end

      result.drain_busy = draining_in;

      // prefetch the data byte that the next pull will need
      if (pos_in == '0 || pos_in > FILL_W'(BLOCK_MAX)) begin
         rd_addr = '0;
      end else begin
         rd_addr = pos_in - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         pos_ff      <= '0;
         draining_ff <= 1'b0;
         tail_ff     <= 1'b0;
         delim_ff    <= 1'b0;
         closing_ff  <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         draining_ff <= draining_in;
         tail_ff     <= tail_in;
         delim_ff    <= delim_in;
         closing_ff  <= closing_in;
      end
   end

   cfe_ram #(
      .WIDTH (8),
      .DEPTH (BLOCK_MAX)
   ) u_block_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (item.raw_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
